FILE: rtl/ascii_decimal_field_parser_defines.svh
// assertion macros for the ascii decimal field parser
`ifndef ASCII_DECIMAL_FIELD_PARSER_DEFINES_SVH
`define ASCII_DECIMAL_FIELD_PARSER_DEFINES_SVH

// property checked on every clock edge outside reset
`define ADFP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// condition in the cycle after the trigger
`define ADFP_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/adfp_pkg.sv
// types, constants and helpers shared by the ascii decimal field parser
`timescale 1ns / 1ps

package adfp_pkg;

    typedef logic [7:0]  t_char;
    typedef logic [31:0] t_whole;
    typedef logic [16:0] t_frac;
    typedef logic [15:0] t_quot;
    typedef logic [2:0]  t_fcount;
    typedef logic [1:0]  t_cfg_idx;
    typedef logic [7:0]  t_cfg_data;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_DIV,
        S_EMIT
    } t_state;

    localparam t_cfg_idx CFG_TERM = 2'd0;
    localparam t_cfg_idx CFG_MAX  = 2'd1;
    localparam t_cfg_idx CFG_MODE = 2'd2;

    localparam t_char CHAR_MINUS = 8'h2D;
    localparam t_char CHAR_POINT = 8'h2E;
    localparam t_char CHAR_ZERO  = 8'h30;
    localparam t_char CHAR_NINE  = 8'h39;

    localparam t_fcount    FRAC_DIGITS = 3'd5;
    localparam logic [3:0] DIV_LAST    = 4'd15;

    localparam t_char TERM_RESET = 8'd0;
    localparam t_char MAX_RESET  = 8'd255;

    function automatic t_frac pow10(input t_fcount n);
        t_frac r;
        case (n)
            3'd0: r = 17'd1;
            3'd1: r = 17'd10;
            3'd2: r = 17'd100;
            3'd3: r = 17'd1000;
            3'd4: r = 17'd10000;
            default: r = 17'd100000;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/adfp_if.sv
// character input and result output channels
`timescale 1ns / 1ps

interface adfp_char_if;
    logic           valid;
    logic           ready;
    adfp_pkg::t_char char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface adfp_res_if;
    logic             valid;
    logic             ready;
    logic             is_negative;
    adfp_pkg::t_whole whole_value;
    adfp_pkg::t_quot  fraction_q16;
    logic             by_terminator;

    modport source (output valid, output is_negative, output whole_value,
                    output fraction_q16, output by_terminator, input ready);
    modport sink   (input valid, input is_negative, input whole_value,
                    input fraction_q16, input by_terminator, output ready);
endinterface

FILE: rtl/ascii_decimal_field_parser.sv
// A character is accepted in S_IDLE and decoded in S_STEP in the cycle after its transfer.
// A closing character gives a result through S_EMIT in integer mode and through S_DIV and
// S_EMIT in decimal mode, where a shared 33-bit adder runs a 16-step restoring division.
// A new character is taken only in S_IDLE, after the previous one is decoded; after a closing
// character, only once its result is loaded, later while the previous result waits at the output.
// Reset clears the field and output valid; registers go to terminator 0, max 255, decimal.
`timescale 1ns / 1ps

`include "ascii_decimal_field_parser_defines.svh"

module ascii_decimal_field_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    adfp_char_if.sink           i_char,
    adfp_res_if.source          o_res,
    input  logic                i_cfg_we,
    input  adfp_pkg::t_cfg_idx  i_cfg_idx,
    input  adfp_pkg::t_cfg_data i_cfg_wdata
);

    adfp_pkg::t_state  r_state;
    adfp_pkg::t_state  n_state;

    adfp_pkg::t_char   r_term;
    adfp_pkg::t_char   r_max;
    logic              r_mode;

    adfp_pkg::t_char   r_char;
    adfp_pkg::t_whole  r_whole_acc;
    adfp_pkg::t_frac   r_frac_acc;
    adfp_pkg::t_fcount r_frac_count;
    logic              r_in_fraction;
    logic              r_negative_seen;
    logic [7:0]        r_char_index;
    logic              r_by_term;
    adfp_pkg::t_quot   r_quot;
    logic [3:0]        r_div_cnt;

    logic              r_out_valid;
    logic              r_out_neg;
    adfp_pkg::t_whole  r_out_whole;
    adfp_pkg::t_quot   r_out_frac;
    logic              r_out_term;

    // shared adder
    logic [31:0]       u_a;
    logic [31:0]       u_b;
    logic              u_sub;
    logic [3:0]        u_cin;
    logic [32:0]       w_sum;

    logic              w_is_term;
    logic              w_is_digit;
    logic [3:0]        w_digit;
    logic [7:0]        w_idx_next;
    logic              w_end;
    logic              w_frac_take;
    logic              w_whole_take;
    logic [17:0]       w_rem2;
    logic              w_out_free;
    logic              w_load_out;

    assign w_sum = {1'b0, u_a} + {1'b0, (u_sub ? ~u_b : u_b)} + 33'(u_cin);

    assign i_char.ready = (r_state == adfp_pkg::S_IDLE);
    assign w_out_free   = !r_out_valid || o_res.ready;
    assign w_load_out   = (r_state == adfp_pkg::S_EMIT) && w_out_free;

    assign o_res.valid         = r_out_valid;
    assign o_res.is_negative   = r_out_neg;
    assign o_res.whole_value   = r_out_whole;
    assign o_res.fraction_q16  = r_out_frac;
    assign o_res.by_terminator = r_out_term;

    always_comb begin
        w_is_term    = (r_char == r_term);
        w_is_digit   = r_char inside {[adfp_pkg::CHAR_ZERO:adfp_pkg::CHAR_NINE]};
        w_digit      = w_is_digit ? 4'(r_char - adfp_pkg::CHAR_ZERO) : 4'd0;
        w_idx_next   = r_char_index + 8'd1;
        w_end        = w_is_term || (w_idx_next >= r_max) || (w_idx_next == 8'd0);
        w_frac_take  = !r_mode && r_in_fraction && w_is_digit
                       && (r_frac_count < adfp_pkg::FRAC_DIGITS);
        w_whole_take = w_is_digit && (r_mode || !r_in_fraction);
        w_rem2       = {r_frac_acc, 1'b0};
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            adfp_pkg::S_IDLE: begin
                if (i_char.valid) begin
                    n_state = adfp_pkg::S_STEP;
                end
            end
            adfp_pkg::S_STEP: begin
                if (w_end) begin
                    n_state = r_mode ? adfp_pkg::S_EMIT : adfp_pkg::S_DIV;
                end else begin
                    n_state = adfp_pkg::S_IDLE;
                end
            end
            adfp_pkg::S_DIV: begin
                if (r_div_cnt == adfp_pkg::DIV_LAST) begin
                    n_state = adfp_pkg::S_EMIT;
                end
            end
            adfp_pkg::S_EMIT: begin
                if (w_out_free) begin
                    n_state = adfp_pkg::S_IDLE;
                end
            end
            default: n_state = adfp_pkg::S_IDLE;
        endcase
    end

    // adder operand selection
    always_comb begin
        u_a   = '0;
        u_b   = '0;
        u_sub = 1'b0;
        u_cin = '0;
        case (r_state)
            adfp_pkg::S_DIV: begin
                u_a   = 32'(w_rem2);
                u_b   = 32'(adfp_pkg::pow10(r_frac_count));
                u_sub = 1'b1;
                u_cin = 4'd1;
            end
            adfp_pkg::S_STEP: begin
                // acc * 10 + digit as (acc << 3) + (acc << 1) + digit
                if (w_frac_take) begin
                    u_a = {12'd0, r_frac_acc, 3'd0};
                    u_b = {14'd0, r_frac_acc, 1'b0};
                end else begin
                    u_a = {r_whole_acc[28:0], 3'd0};
                    u_b = {r_whole_acc[30:0], 1'b0};
                end
                u_cin = w_digit;
            end
            default: begin
                u_a = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= adfp_pkg::S_IDLE;
            r_term          <= adfp_pkg::TERM_RESET;
            r_max           <= adfp_pkg::MAX_RESET;
            r_mode          <= 1'b0;
            r_whole_acc     <= '0;
            r_frac_acc      <= '0;
            r_frac_count    <= '0;
            r_in_fraction   <= 1'b0;
            r_negative_seen <= 1'b0;
            r_char_index    <= '0;
            r_div_cnt       <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    adfp_pkg::CFG_TERM: r_term <= i_cfg_wdata;
                    adfp_pkg::CFG_MAX:  r_max  <= i_cfg_wdata;
                    adfp_pkg::CFG_MODE: r_mode <= i_cfg_wdata[0];
                    default: ;
                endcase
            end

            case (r_state)
                adfp_pkg::S_STEP: begin
                    if (!w_is_term) begin
                        r_char_index <= w_idx_next;
                        if (w_whole_take) begin
                            r_whole_acc <= r_mode ? {16'd0, w_sum[15:0]} : w_sum[31:0];
                        end
                        if (w_frac_take) begin
                            r_frac_acc   <= w_sum[16:0];
                            r_frac_count <= r_frac_count + 3'd1;
                        end
                        if (!r_mode && r_char == adfp_pkg::CHAR_POINT) begin
                            r_in_fraction <= 1'b1;
                        end
                        if (!r_mode && r_char == adfp_pkg::CHAR_MINUS
                            && r_char_index == 8'd0) begin
                            r_negative_seen <= 1'b1;
                        end
                    end
                end
                adfp_pkg::S_DIV: begin
                    r_frac_acc <= w_sum[32] ? w_sum[16:0] : w_rem2[16:0];
                    r_div_cnt  <= r_div_cnt + 4'd1;
                end
                adfp_pkg::S_EMIT: begin
                    if (w_out_free) begin
                        r_whole_acc     <= '0;
                        r_frac_acc      <= '0;
                        r_frac_count    <= '0;
                        r_in_fraction   <= 1'b0;
                        r_negative_seen <= 1'b0;
                        r_char_index    <= '0;
                        r_div_cnt       <= '0;
                    end
                end
                default: ;
            endcase

            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == adfp_pkg::S_IDLE && i_char.valid) begin
            r_char <= i_char.char_code;
        end
        if (r_state == adfp_pkg::S_STEP) begin
            r_by_term <= w_is_term;
        end
        if (r_state == adfp_pkg::S_DIV) begin
            r_quot <= {r_quot[14:0], w_sum[32]};
        end
        if (w_load_out) begin
            r_out_neg   <= r_mode ? 1'b0 : r_negative_seen;
            r_out_whole <= r_mode ? {16'd0, r_whole_acc[15:0]} : r_whole_acc;
            r_out_frac  <= r_mode ? 16'd0 : r_quot;
            r_out_term  <= r_by_term;
        end
    end

    `ADFP_ASSERT(a_div_rem_bound,
        (r_state == adfp_pkg::S_DIV) |-> (r_frac_acc < adfp_pkg::pow10(r_frac_count)),
        "remainder not below divisor")
    `ADFP_ASSERT(a_frac_count_max, r_frac_count <= adfp_pkg::FRAC_DIGITS,
        "too many fraction digits kept")
    `ADFP_ASSERT(a_div_cnt_idle, (r_state != adfp_pkg::S_DIV) |-> (r_div_cnt == 4'd0),
        "division count left over")
    `ADFP_ASSERT_NEXT(a_accept_to_step, i_char.valid && i_char.ready,
        r_state == adfp_pkg::S_STEP, "transfer not decoded")
    `ADFP_ASSERT(a_load_from_emit,
        $rose(r_out_valid) |-> ($past(r_state) == adfp_pkg::S_EMIT),
        "result loaded outside emit")

endmodule
